### rtl/bpfs_pkg.sv
// shared constants and types for the blinn-phong fragment shader
// used by bpfs_norm and blinn_phong_fragment_shade; no dependencies
package bpfs_pkg;

    localparam int VEC_W    = 25;   // signed vector component into a normalizer
    localparam int UNIT_W   = 18;   // signed q.16 unit component, range -1.0 .. 1.0
    localparam int Q16_W    = 17;   // unsigned q.16 in 0 .. 1.0
    localparam int NORM_LAT = 54;   // register stages in one normalizer

    localparam logic signed [VEC_W-1:0] LIGHT_X = 25'sd131072;
    localparam logic signed [VEC_W-1:0] LIGHT_Y = 25'sd65536;
    localparam logic signed [VEC_W-1:0] LIGHT_Z = -25'sd65536;

    localparam logic [Q16_W-1:0] TENTH_Q16 = 17'd6554;
    localparam logic [Q16_W-1:0] ONE_Q16   = 17'd65536;

    typedef logic signed [VEC_W-1:0]  vec_comp_t;
    typedef logic signed [UNIT_W-1:0] unit_comp_t;

    typedef enum logic [2:0] {
        CFG_EYE_X       = 3'd0,
        CFG_EYE_Y       = 3'd1,
        CFG_EYE_Z       = 3'd2,
        CFG_USE_TEXTURE = 3'd3,
        CFG_MODEL_RED   = 3'd4,
        CFG_MODEL_GREEN = 3'd5,
        CFG_MODEL_BLUE  = 3'd6
    } cfg_idx_t;

endpackage

### rtl/bpfs_norm.sv
// pipelined 3-vector normalizer: square sum, even normalizing shift,
// bit-per-stage square root and restoring divide; uses bpfs_pkg
module bpfs_norm
(
    input  logic                  clk,
    input  logic                  adv,
    input  bpfs_pkg::vec_comp_t   v [3],
    output bpfs_pkg::unit_comp_t  u [3]
);

    localparam int SQ_N = 31;
    localparam int DV_N = 17;

    // stage 1: magnitudes and squares
    logic [24:0] mag1 [3];
    logic [2:0]  s1_sg_reg;
    logic [24:0] s1_mg_reg [3];
    logic [48:0] s1_sq_reg [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mag1[c] = v[c][24] ? 25'(-v[c]) : 25'(v[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_sg_reg[c] <= v[c][24];
                s1_mg_reg[c] <= mag1[c];
                s1_sq_reg[c] <= 49'(mag1[c]) * 49'(mag1[c]);
            end
        end
    end

    // stage 2: squared length
    logic [2:0]  s2_sg_reg;
    logic [24:0] s2_mg_reg [3];
    logic [49:0] s2_sum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sg_reg  <= s1_sg_reg;
            s2_mg_reg  <= s1_mg_reg;
            s2_sum_reg <= 50'(s1_sq_reg[0]) + 50'(s1_sq_reg[1]) + 50'(s1_sq_reg[2]);
        end
    end

    // stage 3: coarse shift by 32 and 16
    logic [61:0] t3;
    logic [30:0] m3 [3];
    logic [2:0]  s3_sg_reg;
    logic        s3_zr_reg;
    logic [61:0] s3_t_reg;
    logic [30:0] s3_mg_reg [3];

    always_comb
    begin
        t3 = 62'(s2_sum_reg);
        for (int c = 0; c < 3; c++)
        begin
            m3[c] = 31'(s2_mg_reg[c]);
        end
        if (t3[61:30] == '0)
        begin
            t3 = t3 << 32;
            for (int c = 0; c < 3; c++)
            begin
                m3[c] = m3[c] << 16;
            end
        end
        if (t3[61:46] == '0)
        begin
            t3 = t3 << 16;
            for (int c = 0; c < 3; c++)
            begin
                m3[c] = m3[c] << 8;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sg_reg <= s2_sg_reg;
            s3_zr_reg <= (s2_sum_reg == '0);
            s3_t_reg  <= t3;
            s3_mg_reg <= m3;
        end
    end

    // stage 4: fine shift by 8, 4 and 2; sum lands in [2^60, 2^62)
    logic [61:0] t4;
    logic [30:0] m4 [3];

    logic [61:0] sx_reg [0:SQ_N];
    logic [61:0] sr_reg [0:SQ_N];
    logic [30:0] smg_reg [0:SQ_N][3];
    logic [2:0]  ssg_reg [0:SQ_N];
    logic        szr_reg [0:SQ_N];

    always_comb
    begin
        t4 = s3_t_reg;
        m4 = s3_mg_reg;
        if (t4[61:54] == '0)
        begin
            t4 = t4 << 8;
            for (int c = 0; c < 3; c++)
            begin
                m4[c] = m4[c] << 4;
            end
        end
        if (t4[61:58] == '0)
        begin
            t4 = t4 << 4;
            for (int c = 0; c < 3; c++)
            begin
                m4[c] = m4[c] << 2;
            end
        end
        if (t4[61:60] == '0)
        begin
            t4 = t4 << 2;
            for (int c = 0; c < 3; c++)
            begin
                m4[c] = m4[c] << 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg[0]  <= t4;
            sr_reg[0]  <= '0;
            smg_reg[0] <= m4;
            ssg_reg[0] <= s3_sg_reg;
            szr_reg[0] <= s3_zr_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        localparam logic [61:0] BITC = 62'(1) << (60 - 2 * i);
        logic [61:0] trial;

        assign trial = sr_reg[i] + BITC;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sx_reg[i] >= trial)
                begin
                    sx_reg[i+1] <= sx_reg[i] - trial;
                    sr_reg[i+1] <= (sr_reg[i] >> 1) + BITC;
                end
                else
                begin
                    sx_reg[i+1] <= sx_reg[i];
                    sr_reg[i+1] <= sr_reg[i] >> 1;
                end
                smg_reg[i+1] <= smg_reg[i];
                ssg_reg[i+1] <= ssg_reg[i];
                szr_reg[i+1] <= szr_reg[i];
            end
        end
    end

    // divide setup: numerator is mag * 2^16 plus half the root for rounding
    logic [47:0] dn_reg [0:DV_N][3];
    logic [16:0] dq_reg [0:DV_N][3];
    logic [30:0] dd_reg [0:DV_N];
    logic [2:0]  dsg_reg [0:DV_N];
    logic        dzr_reg [0:DV_N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dn_reg[0][c] <= 48'({smg_reg[SQ_N][c], 16'b0}) + 48'(sr_reg[SQ_N][30:1]);
                dq_reg[0][c] <= '0;
            end
            dd_reg[0]  <= sr_reg[SQ_N][30:0];
            dsg_reg[0] <= ssg_reg[SQ_N];
            dzr_reg[0] <= szr_reg[SQ_N];
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 0; k < DV_N; k++)
    begin : g_div
        localparam int SH = DV_N - 1 - k;
        logic [47:0] trial;

        assign trial = 48'(dd_reg[k]) << SH;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (dn_reg[k][c] >= trial)
                    begin
                        dn_reg[k+1][c] <= dn_reg[k][c] - trial;
                        dq_reg[k+1][c] <= {dq_reg[k][c][15:0], 1'b1};
                    end
                    else
                    begin
                        dn_reg[k+1][c] <= dn_reg[k][c];
                        dq_reg[k+1][c] <= {dq_reg[k][c][15:0], 1'b0};
                    end
                end
                dd_reg[k+1]  <= dd_reg[k];
                dsg_reg[k+1] <= dsg_reg[k];
                dzr_reg[k+1] <= dzr_reg[k];
            end
        end
    end

    // sign and zero-length vector
    bpfs_pkg::unit_comp_t u_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (dzr_reg[DV_N])
                begin
                    u_reg[c] <= '0;
                end
                else if (dsg_reg[DV_N][c])
                begin
                    u_reg[c] <= -$signed(18'(dq_reg[DV_N][c]));
                end
                else
                begin
                    u_reg[c] <= $signed(18'(dq_reg[DV_N][c]));
                end
            end
        end
    end

    assign u = u_reg;

endmodule

### rtl/blinn_phong_fragment_shade.sv
// blinn-phong fragment shader top level: stream in, stream out, config port
// depends on bpfs_pkg and bpfs_norm
//
// one fragment per s_* transaction: normal, position and texel packed in
// s_tdata; one shaded rgba color per m_* transaction in m_tdata.
// the cfg channel writes eye position, base color select and model color;
// cfg_ready is always high, write only while no fragment is in flight.
// throughput: one fragment per cycle while m_tready stays high, set by
// the fully pipelined datapath: three normalizers in parallel, then one
// for the half vector, each a 54 stage pipeline built mostly of square
// root and divide stages, then dot products, the x^10 power chain and
// the color blend.
// when m_tready is low the item on the output is parked in a skid register
// and s_tready drops the next cycle; the whole pipeline holds until the
// skid register drains, so nothing is lost or repeated.
// reset clears all valid bits and the skid valid flag and restores the
// registers: eye at the origin, model color white, model color selected.
module blinn_phong_fragment_shade
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // normal_x, normal_y, normal_z, pos_x, pos_y, pos_z,
    // texel_red, texel_green, texel_blue
    input  logic [143:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // shaded_red, shaded_green, shaded_blue, shaded_alpha
    output logic [31:0]   m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);

    localparam int NL     = bpfs_pkg::NORM_LAT;
    localparam int DLY    = NL + 1;
    localparam int TOT    = 2 * NL + 10;
    localparam int BASE_D = TOT - 2;

    // configuration registers
    logic [23:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic        use_tex_reg;
    logic [7:0]  model_r_reg, model_g_reg, model_b_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg   <= '0;
            eye_y_reg   <= '0;
            eye_z_reg   <= '0;
            use_tex_reg <= 1'b0;
            model_r_reg <= 8'hFF;
            model_g_reg <= 8'hFF;
            model_b_reg <= 8'hFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bpfs_pkg::cfg_idx_t'(cfg_index))
                bpfs_pkg::CFG_EYE_X:       eye_x_reg   <= cfg_data;
                bpfs_pkg::CFG_EYE_Y:       eye_y_reg   <= cfg_data;
                bpfs_pkg::CFG_EYE_Z:       eye_z_reg   <= cfg_data;
                bpfs_pkg::CFG_USE_TEXTURE: use_tex_reg <= cfg_data[0];
                bpfs_pkg::CFG_MODEL_RED:   model_r_reg <= cfg_data[7:0];
                bpfs_pkg::CFG_MODEL_GREEN: model_g_reg <= cfg_data[7:0];
                bpfs_pkg::CFG_MODEL_BLUE:  model_b_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid bits
    logic skid_v_reg;
    logic adv;
    logic vld_reg [0:TOT-1];

    assign adv      = ~skid_v_reg;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k < TOT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 0: light and eye vectors, base color
    logic signed [23:0] pos [3];
    logic signed [23:0] eye [3];
    bpfs_pkg::vec_comp_t light [3];
    bpfs_pkg::vec_comp_t nv_reg [3];
    bpfs_pkg::vec_comp_t tl_reg [3];
    bpfs_pkg::vec_comp_t te_reg [3];
    logic [7:0] base_reg [0:BASE_D-1][3];

    assign pos[0]   = $signed(s_tdata[71:48]);
    assign pos[1]   = $signed(s_tdata[95:72]);
    assign pos[2]   = $signed(s_tdata[119:96]);
    assign eye[0]   = $signed(eye_x_reg);
    assign eye[1]   = $signed(eye_y_reg);
    assign eye[2]   = $signed(eye_z_reg);
    assign light[0] = bpfs_pkg::LIGHT_X;
    assign light[1] = bpfs_pkg::LIGHT_Y;
    assign light[2] = bpfs_pkg::LIGHT_Z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                nv_reg[c] <= 25'($signed(s_tdata[16*c +: 16]));
                tl_reg[c] <= light[c] - 25'(pos[c]);
                te_reg[c] <= 25'(eye[c]) - 25'(pos[c]);
            end
            if (use_tex_reg)
            begin
                base_reg[0][0] <= s_tdata[127:120];
                base_reg[0][1] <= s_tdata[135:128];
                base_reg[0][2] <= s_tdata[143:136];
            end
            else
            begin
                base_reg[0][0] <= model_r_reg;
                base_reg[0][1] <= model_g_reg;
                base_reg[0][2] <= model_b_reg;
            end
            for (int k = 1; k < BASE_D; k++)
            begin
                base_reg[k] <= base_reg[k-1];
            end
        end
    end

    // unit normal, light and eye vectors
    bpfs_pkg::unit_comp_t nu [3];
    bpfs_pkg::unit_comp_t lu [3];
    bpfs_pkg::unit_comp_t eu [3];
    bpfs_pkg::unit_comp_t hu [3];

    bpfs_norm u_norm_n (.clk(clk), .adv(adv), .v(nv_reg), .u(nu));
    bpfs_norm u_norm_l (.clk(clk), .adv(adv), .v(tl_reg), .u(lu));
    bpfs_norm u_norm_e (.clk(clk), .adv(adv), .v(te_reg), .u(eu));

    // half vector sum, normal and light unit vectors wait for its normalizer
    bpfs_pkg::vec_comp_t  hv_reg [3];
    bpfs_pkg::unit_comp_t nd_reg [1:DLY][3];
    bpfs_pkg::unit_comp_t ld_reg [1:DLY][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                hv_reg[c] <= 25'(lu[c]) + 25'(eu[c]);
            end
            nd_reg[1] <= nu;
            ld_reg[1] <= lu;
            for (int k = 2; k <= DLY; k++)
            begin
                nd_reg[k] <= nd_reg[k-1];
                ld_reg[k] <= ld_reg[k-1];
            end
        end
    end

    bpfs_norm u_norm_h (.clk(clk), .adv(adv), .v(hv_reg), .u(hu));

    function automatic logic [16:0] dot_q16(input logic signed [36:0] d);
        logic [20:0] q;
        q = 21'((d + 37'sd32768) >>> 16);
        if (d <= 0)
        begin
            return '0;
        end
        else if (q > 21'(bpfs_pkg::ONE_Q16))
        begin
            return bpfs_pkg::ONE_Q16;
        end
        else
        begin
            return q[16:0];
        end
    endfunction

    function automatic logic [16:0] mul_q16(input logic [16:0] a, input logic [16:0] b);
        logic [33:0] p;
        p = 34'(a) * 34'(b);
        return 17'((p + 34'd32768) >> 16);
    endfunction

    function automatic logic [7:0] sat8(input logic [25:0] acc);
        if (acc[25:16] > 10'd255)
        begin
            return 8'hFF;
        end
        else
        begin
            return acc[23:16];
        end
    endfunction

    // dot products, power chain and color blend
    logic signed [35:0] pl_reg [3];
    logic signed [35:0] ph_reg [3];
    logic [16:0] df2_reg, df3_reg, df4_reg, df5_reg, df6_reg;
    logic [16:0] x_reg, x2_reg, x2d4_reg, x2d5_reg, x4_reg, x8_reg, sp_reg;
    logic [24:0] cb_reg [3];
    logic [24:0] s255_reg;
    logic [7:0]  sh_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pl_reg[c] <= nd_reg[DLY][c] * ld_reg[DLY][c];
                ph_reg[c] <= nd_reg[DLY][c] * hu[c];
            end
            df2_reg  <= dot_q16(37'(pl_reg[0]) + 37'(pl_reg[1]) + 37'(pl_reg[2]));
            x_reg    <= dot_q16(37'(ph_reg[0]) + 37'(ph_reg[1]) + 37'(ph_reg[2]));
            x2_reg   <= mul_q16(x_reg, x_reg);
            df3_reg  <= df2_reg;
            x4_reg   <= mul_q16(x2_reg, x2_reg);
            x2d4_reg <= x2_reg;
            df4_reg  <= df3_reg;
            x8_reg   <= mul_q16(x4_reg, x4_reg);
            x2d5_reg <= x2d4_reg;
            df5_reg  <= df4_reg;
            sp_reg   <= mul_q16(x8_reg, x2d5_reg);
            df6_reg  <= df5_reg;
            for (int c = 0; c < 3; c++)
            begin
                cb_reg[c] <= 25'(base_reg[BASE_D-1][c])
                           * 25'(18'(bpfs_pkg::TENTH_Q16) + 18'(df6_reg));
            end
            s255_reg <= (25'(sp_reg) << 8) - 25'(sp_reg);
            for (int c = 0; c < 3; c++)
            begin
                sh_reg[c] <= sat8(26'(cb_reg[c]) + 26'(s255_reg) + 26'd32768);
            end
        end
    end

    // output skid register
    logic [31:0] out_d;
    logic [31:0] skid_d_reg;

    assign out_d    = {8'hFF, sh_reg[2], sh_reg[1], sh_reg[0]};
    assign m_tvalid = skid_v_reg | vld_reg[TOT-1];
    assign m_tdata  = skid_v_reg ? skid_d_reg : out_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_tready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (vld_reg[TOT-1] && !m_tready)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_d_reg <= out_d;
        end
    end

endmodule
